FILE: rtl/core/dti_pp_pkg.sv
// Shared types, constants and helpers of the diffusion-tensor pre-processor.
package dti_pp_pkg;

	localparam int QW = 32;
	localparam int NC = 6;
	localparam int DETW = 100;

	// component order, lowest index first: xx, xy, xz, yy, yz, zz
	typedef logic [NC-1:0][QW-1:0] tens_t;

	typedef struct packed {
		logic en;
		logic do_pow;
		logic do_div;
		logic deg;
		logic sat;
	} ctl_t;

	typedef struct packed {
		logic        enable;
		logic [23:0] gain_q8;
		logic [1:0]  sharpen_mode;
		logic [15:0] aniso_threshold;
		logic [3:0]  power;
	} cfg_t;

	typedef enum logic [2:0] {
		CFG_ENABLE          = 3'd0,
		CFG_GAIN_Q8         = 3'd1,
		CFG_SHARPEN_MODE    = 3'd2,
		CFG_ANISO_THRESHOLD = 3'd3,
		CFG_POWER           = 3'd4
	} cfg_idx_t;

	localparam logic        ENABLE_RST = 1'b0;
	localparam logic [23:0] GAIN_RST   = 24'd512000;
	localparam logic [1:0]  MODE_RST   = 2'd0;
	localparam logic [15:0] THRESH_RST = 16'd6554;
	localparam logic [3:0]  POWER_RST  = 4'd2;

	// gain of 1.0: t*256 rounded at bit 20 equals the plain Q4.28 -> Q16.16 rounding
	localparam logic [23:0] GAIN_UNITY = 24'd256;

	localparam logic [QW-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [QW-1:0] Q_MAX   = 32'h7FFF_FFFF;
	localparam logic [QW-1:0] Q_MIN   = 32'h8000_0000;

	// 0.0001 in Q48.48
	localparam logic signed [DETW-1:0] DET_EPS = 100'sd28147497671;

	// operand indexes of the symmetric product A*T, three terms per result component
	localparam logic [2:0] POW_A [NC][3] = '{
		'{3'd0, 3'd1, 3'd2}, '{3'd0, 3'd1, 3'd2}, '{3'd0, 3'd1, 3'd2},
		'{3'd1, 3'd3, 3'd4}, '{3'd1, 3'd3, 3'd4}, '{3'd2, 3'd4, 3'd5}};
	localparam logic [2:0] POW_B [NC][3] = '{
		'{3'd0, 3'd1, 3'd2}, '{3'd1, 3'd3, 3'd4}, '{3'd2, 3'd4, 3'd5},
		'{3'd1, 3'd3, 3'd4}, '{3'd2, 3'd4, 3'd5}, '{3'd2, 3'd4, 3'd5}};

	// {clamped, value}
	function automatic logic [QW:0] sat32(input logic signed [63:0] v);
		logic [QW:0] r;
		if (v > 64'sd2147483647) begin
			r = {1'b1, Q_MAX};
		end else if (v < -64'sd2147483648) begin
			r = {1'b1, Q_MIN};
		end else begin
			r = {1'b0, v[QW-1:0]};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/dti_tensor_preprocess_top.sv
// Top level of the diffusion-tensor pre-processor: registers, pipeline and output buffer.
//
// Takes one tensor transaction per clock while the output buffer has room and returns
// one result transaction per tensor, in order. The path runs through the gain stages,
// the determinant, the power chain and the trace divider, then the output buffer; every
// stage is passed whether sharpening applies or not, so throughput is one tensor per
// cycle unless that buffer is full. A two-entry output buffer lets the pipeline keep
// accepting while a result waits; the whole pipeline holds only when it is full.
// Configuration writes take effect at once and belong in idle periods. power is clamped to MAX_POWER.
module dti_tensor_preprocess_top #(
	parameter int MAX_POWER = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [207:0] s_axis_tdata,  // txx, txy, txz, tyy, tyz, tzz, anisotropy
	input  logic [0:0]   s_axis_tuser,  // scalar_present
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,  // oxx, oxy, oxz, oyy, oyz, ozz
	output logic [1:0]   m_axis_tuser,  // degenerate, saturated
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	dti_pp_pkg::cfg_t cfg_q;
	logic adv;
	logic [1:0] cnt_q;

	logic              gn_v;
	dti_pp_pkg::tens_t gn_t;
	dti_pp_pkg::ctl_t  gn_c;

	logic              pw_v [MAX_POWER];
	dti_pp_pkg::tens_t pw_a [MAX_POWER];
	dti_pp_pkg::tens_t pw_t [MAX_POWER];
	dti_pp_pkg::ctl_t  pw_c [MAX_POWER];

	logic              dv_v;
	dti_pp_pkg::tens_t dv_t;
	dti_pp_pkg::ctl_t  dv_c;

	dti_pp_pkg::tens_t head_q, skid_q;
	logic [1:0]        hflag_q, sflag_q;
	logic push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= dti_pp_pkg::ENABLE_RST;
			cfg_q.gain_q8 <= dti_pp_pkg::GAIN_RST;
			cfg_q.sharpen_mode <= dti_pp_pkg::MODE_RST;
			cfg_q.aniso_threshold <= dti_pp_pkg::THRESH_RST;
			cfg_q.power <= dti_pp_pkg::POWER_RST;
		end else if (cfg_valid) begin
			unique case (dti_pp_pkg::cfg_idx_t'(cfg_index))
				dti_pp_pkg::CFG_ENABLE:          cfg_q.enable <= cfg_data[0];
				dti_pp_pkg::CFG_GAIN_Q8:         cfg_q.gain_q8 <= cfg_data;
				dti_pp_pkg::CFG_SHARPEN_MODE:    cfg_q.sharpen_mode <= cfg_data[1:0];
				dti_pp_pkg::CFG_ANISO_THRESHOLD: cfg_q.aniso_threshold <= cfg_data[15:0];
				dti_pp_pkg::CFG_POWER:           cfg_q.power <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign adv = (cnt_q != 2'd2);
	assign s_axis_tready = adv;

	dti_pp_gain u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_axis_tvalid),
		.in_t     (s_axis_tdata[191:0]),
		.aniso    (s_axis_tdata[207:192]),
		.present  (s_axis_tuser[0]),
		.cfg      (cfg_q),
		.v_s2     (gn_v),
		.t_s2     (gn_t),
		.ctl_s2   (gn_c)
	);

	dti_pp_det u_det (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (gn_v),
		.in_t     (gn_t),
		.in_ctl   (gn_c),
		.v_s5     (pw_v[0]),
		.t_s5     (pw_t[0]),
		.ctl_s5   (pw_c[0])
	);

	assign pw_a[0] = pw_t[0];

	for (genvar g = 1; g < MAX_POWER; g++) begin : g_pow
		dti_pp_pow #(
			.STEP (g)
		) u_pow (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.power    (cfg_q.power),
			.in_valid (pw_v[g-1]),
			.in_a     (pw_a[g-1]),
			.in_t     (pw_t[g-1]),
			.in_ctl   (pw_c[g-1]),
			.v_s2     (pw_v[g]),
			.a_s2     (pw_a[g]),
			.t_s2     (pw_t[g]),
			.ctl_s2   (pw_c[g])
		);
	end

	dti_pp_tdiv u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (pw_v[MAX_POWER-1]),
		.in_t     (pw_a[MAX_POWER-1]),
		.in_ctl   (pw_c[MAX_POWER-1]),
		.v_out    (dv_v),
		.t_out    (dv_t),
		.ctl_out  (dv_c)
	);

	assign push = adv && dv_v;
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || (pop && cnt_q == 2'd1))) begin
			head_q <= dv_t;
			hflag_q <= {dv_c.sat, dv_c.deg};
		end else if (pop) begin
			head_q <= skid_q;
			hflag_q <= sflag_q;
		end
		if (push && cnt_q != 2'd0 && !(pop && cnt_q == 2'd1)) begin
			skid_q <= dv_t;
			sflag_q <= {dv_c.sat, dv_c.deg};
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata = head_q;
	assign m_axis_tuser = hflag_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> u_gain.v_s1)
		else $error("accepted transaction missing from gain stage");

	a_pass_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !cfg_q.enable |-> m_axis_tuser == 2'b00)
		else $error("flags raised in pass-through");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] && cfg_q.sharpen_mode == 2'd0 |->
		m_axis_tdata[31:0] == dti_pp_pkg::ONE_Q16 && m_axis_tdata[63:32] == '0)
		else $error("degenerate result is not the identity");
`endif

endmodule

FILE: rtl/core/dti_pp_gain.sv
// Gain stage: component times gain, rounding to Q16.16, clamping, sharpening decision.
module dti_pp_gain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  dti_pp_pkg::tens_t   in_t,
	input  logic [15:0]         aniso,
	input  logic                present,
	input  dti_pp_pkg::cfg_t    cfg,
	output logic                v_s2,
	output dti_pp_pkg::tens_t   t_s2,
	output dti_pp_pkg::ctl_t    ctl_s2
);

	logic                     v_s1;
	logic signed [56:0]       prod_s1 [dti_pp_pkg::NC];
	dti_pp_pkg::ctl_t         ctl_s1;
	logic [23:0]              gain;
	logic                     sharpen;
	dti_pp_pkg::tens_t        t_nx;
	logic [dti_pp_pkg::NC-1:0] sat_nx;

	assign gain = cfg.enable ? cfg.gain_q8 : dti_pp_pkg::GAIN_UNITY;
	assign sharpen = cfg.enable && present && (cfg.sharpen_mode != 2'd0) &&
		(aniso < cfg.aniso_threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < dti_pp_pkg::NC; i++) begin
				prod_s1[i] <= $signed(in_t[i]) * $signed({1'b0, gain});
			end
			ctl_s1.en     <= cfg.enable;
			ctl_s1.do_pow <= sharpen && cfg.sharpen_mode[0];
			ctl_s1.do_div <= sharpen && cfg.sharpen_mode[1];
			ctl_s1.deg    <= 1'b0;
			ctl_s1.sat    <= 1'b0;
		end
	end

	always_comb begin
		logic signed [56:0]     rnd;
		logic [dti_pp_pkg::QW:0] s;
		for (int i = 0; i < dti_pp_pkg::NC; i++) begin
			rnd = prod_s1[i] + 57'sd524288;
			s = dti_pp_pkg::sat32({{27{rnd[56]}}, rnd[56:20]});
			t_nx[i] = s[dti_pp_pkg::QW-1:0];
			sat_nx[i] = s[dti_pp_pkg::QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2 <= t_nx;
			ctl_s2 <= {ctl_s1.en, ctl_s1.do_pow, ctl_s1.do_div, ctl_s1.deg, |sat_nx};
		end
	end

endmodule

FILE: rtl/core/dti_pp_det.sv
// Exact Q48.48 determinant, five stages; if enabled, near-zero input becomes identity.
module dti_pp_det (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  dti_pp_pkg::tens_t   in_t,
	input  dti_pp_pkg::ctl_t    in_ctl,
	output logic                v_s5,
	output dti_pp_pkg::tens_t   t_s5,
	output dti_pp_pkg::ctl_t    ctl_s5
);

	logic v_s1, v_s2, v_s3, v_s4;
	dti_pp_pkg::tens_t t_s1, t_s2, t_s3, t_s4;
	dti_pp_pkg::ctl_t  ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [63:0] p_s1 [6];
	logic signed [64:0] cof_s2 [3];
	logic signed [64:0] lo_s3 [3];
	logic signed [64:0] hi_s3 [3];
	logic signed [dti_pp_pkg::DETW-1:0] det_s4;
	logic signed [dti_pp_pkg::DETW-1:0] det_sum;
	logic near_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// cofactors along the first row and their products with that row
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= $signed(in_t[3]) * $signed(in_t[5]);
			p_s1[1] <= $signed(in_t[4]) * $signed(in_t[4]);
			p_s1[2] <= $signed(in_t[2]) * $signed(in_t[4]);
			p_s1[3] <= $signed(in_t[1]) * $signed(in_t[5]);
			p_s1[4] <= $signed(in_t[1]) * $signed(in_t[4]);
			p_s1[5] <= $signed(in_t[2]) * $signed(in_t[3]);
			t_s1 <= in_t;
			ctl_s1 <= in_ctl;

			for (int i = 0; i < 3; i++) begin
				cof_s2[i] <= $signed({p_s1[2*i][63], p_s1[2*i]}) -
					$signed({p_s1[2*i+1][63], p_s1[2*i+1]});
			end
			t_s2 <= t_s1;
			ctl_s2 <= ctl_s1;

			for (int i = 0; i < 3; i++) begin
				lo_s3[i] <= $signed({1'b0, cof_s2[i][31:0]}) * $signed(t_s2[i]);
				hi_s3[i] <= $signed(cof_s2[i][64:32]) * $signed(t_s2[i]);
			end
			t_s3 <= t_s2;
			ctl_s3 <= ctl_s2;

			det_s4 <= det_sum;
			t_s4 <= t_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	always_comb begin
		det_sum = '0;
		for (int i = 0; i < 3; i++) begin
			det_sum = det_sum + $signed({{3{hi_s3[i][64]}}, hi_s3[i], 32'b0}) +
				$signed({{35{lo_s3[i][64]}}, lo_s3[i]});
		end
	end

	assign near_zero = (det_s4 <= dti_pp_pkg::DET_EPS) && (det_s4 >= -dti_pp_pkg::DET_EPS);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (near_zero && ctl_s4.en) begin
				t_s5 <= {dti_pp_pkg::ONE_Q16, 32'h0, dti_pp_pkg::ONE_Q16, 32'h0, 32'h0,
					dti_pp_pkg::ONE_Q16};
				ctl_s5 <= {ctl_s4.en, ctl_s4.do_pow, ctl_s4.do_div, 1'b1, ctl_s4.sat};
			end else begin
				t_s5 <= t_s4;
				ctl_s5 <= ctl_s4;
			end
		end
	end

endmodule

FILE: rtl/core/dti_pp_pow.sv
// One matrix product A*T of the power chain: products, then rounded three-term sums.
module dti_pp_pow #(
	parameter int unsigned STEP = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [3:0]          power,
	input  logic                in_valid,
	input  dti_pp_pkg::tens_t   in_a,
	input  dti_pp_pkg::tens_t   in_t,
	input  dti_pp_pkg::ctl_t    in_ctl,
	output logic                v_s2,
	output dti_pp_pkg::tens_t   a_s2,
	output dti_pp_pkg::tens_t   t_s2,
	output dti_pp_pkg::ctl_t    ctl_s2
);

	logic v_s1;
	logic act_s1;
	logic signed [63:0] prod_s1 [dti_pp_pkg::NC][3];
	dti_pp_pkg::tens_t a_s1, t_s1;
	dti_pp_pkg::ctl_t  ctl_s1;
	dti_pp_pkg::tens_t b_nx;
	logic [dti_pp_pkg::NC-1:0] sat_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < dti_pp_pkg::NC; j++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[j][k] <= $signed(in_a[dti_pp_pkg::POW_A[j][k]]) *
						$signed(in_t[dti_pp_pkg::POW_B[j][k]]);
				end
			end
			act_s1 <= in_ctl.do_pow && (32'(power) > STEP);
			a_s1 <= in_a;
			t_s1 <= in_t;
			ctl_s1 <= in_ctl;
		end
	end

	always_comb begin
		logic signed [49:0]      acc;
		logic [dti_pp_pkg::QW:0] s;
		for (int j = 0; j < dti_pp_pkg::NC; j++) begin
			acc = '0;
			for (int k = 0; k < 3; k++) begin
				acc = acc + $signed({{2{prod_s1[j][k][63]}}, prod_s1[j][k][63:16]}) +
					$signed({49'b0, prod_s1[j][k][15]});
			end
			s = dti_pp_pkg::sat32({{14{acc[49]}}, acc});
			b_nx[j] = s[dti_pp_pkg::QW-1:0];
			sat_nx[j] = s[dti_pp_pkg::QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2 <= t_s1;
			if (act_s1) begin
				a_s2 <= b_nx;
				ctl_s2 <= {ctl_s1.en, ctl_s1.do_pow, ctl_s1.do_div, ctl_s1.deg,
					ctl_s1.sat | (|sat_nx)};
			end else begin
				a_s2 <= a_s1;
				ctl_s2 <= ctl_s1;
			end
		end
	end

endmodule

FILE: rtl/core/dti_pp_tdiv.sv
// Trace division: pipelined restoring divider, one quotient bit per stage, six lanes.
module dti_pp_tdiv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  dti_pp_pkg::tens_t   in_t,
	input  dti_pp_pkg::ctl_t    in_ctl,
	output logic                v_out,
	output dti_pp_pkg::tens_t   t_out,
	output dti_pp_pkg::ctl_t    ctl_out
);

	localparam int DIV_STEPS = dti_pp_pkg::QW;
	localparam int NC = dti_pp_pkg::NC;

	function automatic logic [66:0] div_step(input logic [34:0] rem, input logic [31:0] qn,
		input logic [33:0] d);
		logic [34:0] r2;
		logic        ge;
		r2 = {rem[33:0], qn[31]};
		ge = r2 >= {1'b0, d};
		return {ge ? r2 - {1'b0, d} : r2, qn[30:0], ge};
	endfunction

	// stage 1: trace and magnitudes
	logic v_s1;
	logic [33:0] dmag_s1;
	logic [31:0] cmag_s1 [NC];
	logic [NC-1:0] neg_s1;
	dti_pp_pkg::tens_t a_s1;
	dti_pp_pkg::ctl_t  ctl_s1;

	logic signed [33:0] tr;
	logic signed [33:0] trz;

	// divider stages, index 0 is the setup stage
	logic              v_s   [DIV_STEPS+1];
	logic [34:0]       rem_s [DIV_STEPS+1][NC];
	logic [31:0]       qn_s  [DIV_STEPS+1][NC];
	logic [33:0]       dmag_s [DIV_STEPS+1];
	logic [NC-1:0]     neg_s [DIV_STEPS+1];
	logic [NC-1:0]     ovf_s [DIV_STEPS+1];
	dti_pp_pkg::tens_t a_s   [DIV_STEPS+1];
	dti_pp_pkg::ctl_t  ctl_s [DIV_STEPS+1];

	dti_pp_pkg::tens_t q_nx;
	logic [NC-1:0]     sat_nx;

	assign tr = $signed({{2{in_t[0][31]}}, in_t[0]}) + $signed({{2{in_t[3][31]}}, in_t[3]}) +
		$signed({{2{in_t[5][31]}}, in_t[5]});
	assign trz = (tr == '0) ? 34'sd65536 : tr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) begin
				v_s[k] <= 1'b0;
			end
			v_out <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s[0] <= v_s1;
			for (int k = 0; k < DIV_STEPS; k++) begin
				v_s[k+1] <= v_s[k];
			end
			v_out <= v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dmag_s1 <= trz[33] ? 34'(-trz) : trz;
			for (int i = 0; i < NC; i++) begin
				cmag_s1[i] <= in_t[i][31] ? 32'(-in_t[i]) : in_t[i];
				neg_s1[i] <= in_t[i][31] ^ trz[33];
			end
			a_s1 <= in_t;
			ctl_s1 <= in_ctl;

			// quotient needs more than 32 bits when |c| >= |tr| * 2^16
			for (int i = 0; i < NC; i++) begin
				ovf_s[0][i] <= {18'b0, cmag_s1[i]} >= {dmag_s1, 16'b0};
				rem_s[0][i] <= {19'b0, cmag_s1[i][31:16]};
				qn_s[0][i] <= {cmag_s1[i][15:0], 16'b0};
			end
			dmag_s[0] <= dmag_s1;
			neg_s[0] <= neg_s1;
			a_s[0] <= a_s1;
			ctl_s[0] <= ctl_s1;

			for (int k = 0; k < DIV_STEPS; k++) begin
				for (int i = 0; i < NC; i++) begin
					{rem_s[k+1][i], qn_s[k+1][i]} <= div_step(rem_s[k][i], qn_s[k][i], dmag_s[k]);
				end
				dmag_s[k+1] <= dmag_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
				a_s[k+1] <= a_s[k];
				ctl_s[k+1] <= ctl_s[k];
			end
		end
	end

	always_comb begin
		logic [31:0] q;
		for (int i = 0; i < NC; i++) begin
			q = qn_s[DIV_STEPS][i];
			if (ovf_s[DIV_STEPS][i]) begin
				q_nx[i] = neg_s[DIV_STEPS][i] ? dti_pp_pkg::Q_MIN : dti_pp_pkg::Q_MAX;
				sat_nx[i] = 1'b1;
			end else if (!neg_s[DIV_STEPS][i]) begin
				q_nx[i] = q[31] ? dti_pp_pkg::Q_MAX : q;
				sat_nx[i] = q[31];
			end else if (q > dti_pp_pkg::Q_MIN) begin
				q_nx[i] = dti_pp_pkg::Q_MIN;
				sat_nx[i] = 1'b1;
			end else begin
				q_nx[i] = ~q + 32'd1;
				sat_nx[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctl_s[DIV_STEPS].do_div) begin
				t_out <= q_nx;
				ctl_out <= {ctl_s[DIV_STEPS].en, ctl_s[DIV_STEPS].do_pow,
					ctl_s[DIV_STEPS].do_div, ctl_s[DIV_STEPS].deg,
					ctl_s[DIV_STEPS].sat | (|sat_nx)};
			end else begin
				t_out <= a_s[DIV_STEPS];
				ctl_out <= ctl_s[DIV_STEPS];
			end
		end
	end

endmodule
